FILE: rtl/itoa_pkg.sv
// Shared constants, command/status types and the digit encoder for the integer to ASCII block.
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned CHAR_W         = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DECIMAL_RADIX = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // take a new request
    logic div_step;    // one restoring division step
    logic store;       // push the remainder digit
    logic pop;         // read back the most recent digit
    logic emit_sign;   // place '-' in the output register
    logic emit_digit;  // place the read digit in the output register
  } itoa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic step_last;   // final division step of this digit
    logic quot_zero;   // quotient has reached zero
    logic negative;    // decimal request with negative value
    logic rd_last;     // digit read back is the least significant one
    logic out_free;    // output register can take a character
  } itoa_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dc;
    dc = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < DECIMAL_RADIX) begin
      return CHAR_ZERO + dc;
    end
    return CHAR_UPPER_A + (dc - CHAR_W'(DECIMAL_RADIX));
  endfunction

endpackage

FILE: rtl/itoa_dpath.sv
// Datapath: radix divider, digit stack and output register.
module itoa_dpath
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itoa_cmd_t             cmd_i,
  output itoa_status_t          status_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [RADIX_W-1:0]    radix_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  out_last_o
);

  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned IDX_W  = $clog2(VALUE_BITS);
  localparam int unsigned STEP_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    radix_q, radix_d;
  logic                  neg_q, neg_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [RADIX_W-1:0]    rd_q;
  logic                  rd_last_q;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q;
  logic                  out_last_q;

  logic [RADIX_W-1:0]    digits_mem [VALUE_BITS];

  logic [RADIX_W:0]      trial;
  logic                  ge;
  logic [CNT_W-1:0]      cnt_dec;
  logic [RADIX_W-1:0]    radix_clamped;
  logic                  value_neg;

  always_comb begin
    radix_clamped = radix_i;
    if (radix_i < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end
    value_neg = (radix_clamped == DECIMAL_RADIX) && value_i[VALUE_BITS-1];
  end

  assign trial   = {rem_q, mag_q[VALUE_BITS-1]};
  assign ge      = trial >= {1'b0, radix_q};
  assign cnt_dec = count_q - CNT_W'(1);

  always_comb begin
    mag_d   = mag_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    step_d  = step_q;
    count_d = count_q;
    if (cmd_i.load) begin
      radix_d = radix_clamped;
      neg_d   = value_neg;
      mag_d   = value_neg ? (VALUE_BITS'(0) - value_i) : value_i;
      rem_d   = '0;
      step_d  = '0;
      count_d = '0;
    end else if (cmd_i.div_step) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d  = ge ? RADIX_W'(trial - {1'b0, radix_q}) : trial[RADIX_W-1:0];
      mag_d  = {mag_q[VALUE_BITS-2:0], ge};
      step_d = step_q + STEP_W'(1);
    end else if (cmd_i.store) begin
      rem_d   = '0;
      step_d  = '0;
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = cnt_dec;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    neg_q   <= neg_d;
    if (cmd_i.emit_sign) begin
      out_char_q <= CHAR_MINUS;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_char_q <= digit_char(rd_q);
      out_last_q <= rd_last_q;
    end
  end

  // Digit stack: least significant digit pushed first, read back in reverse
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      digits_mem[count_q[IDX_W-1:0]] <= rem_q;
    end
    if (cmd_i.pop) begin
      rd_q      <= digits_mem[cnt_dec[IDX_W-1:0]];
      rd_last_q <= (count_q == CNT_W'(1));
    end
  end

  assign status_o.step_last = (step_q == STEP_W'(VALUE_BITS - 1));
  assign status_o.quot_zero = (mag_q == '0);
  assign status_o.negative  = neg_q;
  assign status_o.rd_last   = rd_last_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  a_store_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> count_q < CNT_W'(VALUE_BITS))
    else $error("digit stack overflow");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("digit stack read while empty");

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_sign || cmd_i.emit_digit) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while held");

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_step) |-> rem_q < radix_q)
    else $error("remainder not below radix");

endmodule

FILE: rtl/itoa_ctrl.sv
// Controller: sequences load, digit divisions, sign and digit emission.
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  itoa_status_t status_i,
  output itoa_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_STORE = 6'b000100,
    S_SIGN  = 6'b001000,
    S_READ  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        // a zero quotient ends the digit loop; zero itself still yields one digit
        if (!status_i.quot_zero) begin
          state_d = S_DIV;
        end else if (status_i.negative) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_READ;
        end
      end
      S_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.pop = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          state_d          = status_i.rd_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DIV)
    else $error("load did not start division");

  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |-> status_i.rd_last)
    else $error("request finished before last digit");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

endmodule

FILE: rtl/integer_to_ascii_digits.sv
// Sequence: each of a request's digits comes from the bit-serial radix divider (one quotient
// bit per cycle), then each character passes through the registered digit stack into the
// output register, which waits while the output is held; a sign goes out before the digits.
// Throughput: one request at a time; the next is taken once the last character is registered.
// Reset: asynchronous, active low; clears the controller and the output valid, no store sweep.
module integer_to_ascii_digits
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // fields from bit 0: value [VALUE_BITS], radix [6], zero fill
  input  logic [((VALUE_BITS + RADIX_W + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                                         m_axis_tvalid_o,
  input  logic                                         m_axis_tready_i,
  // fields from bit 0: character [8]
  output logic [CHAR_W-1:0]                            m_axis_tdata_o,
  output logic                                         m_axis_tlast_o
);

  itoa_cmd_t    cmd;
  itoa_status_t status;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itoa_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (s_axis_tdata_i[VALUE_BITS-1:0]),
    .radix_i     (s_axis_tdata_i[VALUE_BITS+RADIX_W-1:VALUE_BITS]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

FILE: tb/itoa_string_checker.sv
// Stream monitor that predicts the ASCII digit string for each request and checks every character.
module itoa_string_checker
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned TDATA_W    = ((VALUE_BITS + RADIX_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  // fields from bit 0: value [VALUE_BITS], radix [6], zero fill
  input  logic [TDATA_W-1:0] s_axis_tdata_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  // fields from bit 0: character [8]
  input  logic [CHAR_W-1:0]  m_axis_tdata_i,
  input  logic               m_axis_tlast_i,
  output int                 mismatches_o,
  output int                 requests_seen_o,
  output int                 chars_pending_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_exp_t;

  char_exp_t expected_chars[$];
  int        fail_tally = 0;
  int        request_tally = 0;

  // Queue the characters that one request should produce, most significant first.
  function automatic void predict_string(input logic [VALUE_BITS-1:0] raw,
                                         input logic [RADIX_W-1:0]    radix_field);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] rem;
    logic [RADIX_W-1:0]    base;
    logic [CHAR_W-1:0]     digit_stack[$];
    base = radix_field;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    mag = raw;
    // Only decimal is signed; the most negative value negates onto itself as unsigned.
    if (base == DECIMAL_RADIX && raw[VALUE_BITS-1]) begin
      mag = -raw;
      expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
    end
    do begin
      rem = mag % base;
      digit_stack.push_front(rem < DECIMAL_RADIX ? CHAR_ZERO + CHAR_W'(rem)
                                                 : CHAR_UPPER_A + CHAR_W'(rem - DECIMAL_RADIX));
      mag = mag / base;
    end while (mag != '0);
    foreach (digit_stack[i]) begin
      expected_chars.push_back('{ch: digit_stack[i], last: (i == digit_stack.size() - 1)});
    end
  endfunction

  always @(posedge clk_i) begin
    char_exp_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_string(s_axis_tdata_i[VALUE_BITS-1:0],
                       s_axis_tdata_i[VALUE_BITS +: RADIX_W]);
        request_tally++;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character, expected none, actual %h last %b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
          fail_tally++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata_i !== want.ch) begin
            $display("%0t: character mismatch, expected %h, actual %h",
                     $time, want.ch, m_axis_tdata_i);
            fail_tally++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $display("%0t: last flag mismatch, expected %b, actual %b",
                     $time, want.last, m_axis_tlast_i);
            fail_tally++;
          end
        end
      end
    end
    // Publish after the edge so the stimulus side never races the update.
    mismatches_o    <= fail_tally;
    requests_seen_o <= request_tally;
    chars_pending_o <= expected_chars.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the integer to ASCII testbench: clock, reset, request stimulus, output pacing and verdict.
module tb;
  import itoa_pkg::*;

  localparam int unsigned VALUE_BITS      = 32;
  localparam int unsigned TDATA_W         = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;
  localparam int          PRESSURE_CYCLES = 400;
  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES    = 64;
  localparam int          RANDOM_PER_PHASE = 62;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [CHAR_W-1:0]  m_tdata;
  logic               m_tlast;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic pressure_req = 1'b0;
  logic pressure_done = 1'b0;
  int   hold_left = 0;
  int   stall_cycles = 0;
  int   requests_sent = 0;
  int   mismatches;
  int   requests_seen;
  int   chars_pending;

  integer_to_ascii_digits #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  itoa_string_checker #(.VALUE_BITS(VALUE_BITS)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .mismatches_o    (mismatches),
    .requests_seen_o (requests_seen),
    .chars_pending_o (chars_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, plus one long hold-off once asked for.
  always @(posedge clk_i) begin
    if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= PRESSURE_CYCLES;
      m_tready      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Abort if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [VALUE_BITS-1:0] value, input logic [RADIX_W-1:0] radix);
    logic [TDATA_W-1:0] word;
    word = '0;
    word[VALUE_BITS-1:0]        = value;
    word[VALUE_BITS +: RADIX_W] = radix;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    // Hold until the edge at which the block takes the request.
    do @(posedge clk_i); while (!s_tready);
    requests_sent++;
  endtask

  task automatic random_requests(input int n);
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
    repeat (n) begin
      case ($urandom_range(5))
        0, 5:    value = $urandom;
        1:       value = $urandom_range(999);
        2:       value = -VALUE_BITS'($urandom_range(1000, 1));
        3:       value = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: value = (32'd1 << $urandom_range(31)) - $urandom_range(1);
      endcase
      case ($urandom_range(7))
        0, 1:    radix = DECIMAL_RADIX;
        2:       radix = RADIX_W'($urandom_range(63));
        default: radix = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
      endcase
      send_request(value, radix);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni      <= 1'b1;
    tx_idle_pct <= 10;
    rx_idle_pct <= 48;
    @(posedge clk_i);

    // Zero, single digits, letter digits and the sign extremes.
    send_request(32'd0, DECIMAL_RADIX);
    send_request(32'd0, RADIX_MIN);
    send_request(32'd1, RADIX_MIN);
    send_request(32'd9, DECIMAL_RADIX);
    send_request(32'd10, 6'd16);
    send_request(32'd35, RADIX_MAX);
    send_request(32'd36, RADIX_MAX);
    send_request(32'h8000_0000, DECIMAL_RADIX);
    send_request(32'h8000_0000, 6'd16);
    send_request(32'h8000_0000, RADIX_MIN);
    send_request(32'hFFFF_FFFF, RADIX_MIN);
    send_request(32'hFFFF_FFFF, DECIMAL_RADIX);
    send_request(32'hFFFF_FFFF, 6'd16);
    send_request(32'hFFFF_FFFF, RADIX_MAX);
    send_request(32'h7FFF_FFFF, DECIMAL_RADIX);
    send_request(32'h7FFF_FFFF, RADIX_MAX);
    send_request(-32'sd12345, DECIMAL_RADIX);
    send_request(32'd12345, 6'd8);
    // Radix clamping below two and above thirty-six, then radices three, ten and thirty-five.
    send_request(32'd255, 6'd0);
    send_request(32'd255, 6'd1);
    send_request(32'd1295, 6'd37);
    send_request(32'hFFFF_FFFF, 6'd63);
    send_request(32'hAAAA_AAAA, 6'd3);
    send_request(32'h5555_5555, DECIMAL_RADIX);
    send_request(32'hDEAD_BEEF, 6'd35);

    // Stall the output for a long stretch while requests keep coming.
    pressure_req <= 1'b1;
    random_requests(RANDOM_PER_PHASE);

    tx_idle_pct <= 48;
    rx_idle_pct <= 10;
    random_requests(RANDOM_PER_PHASE);

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    random_requests(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;

    do @(posedge clk_i); while (requests_seen != requests_sent || chars_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
